// ----- rtl/core/ksrp_pkg.sv -----
package ksrp_pkg;

    localparam int unsigned KEY_W       = 32;
    localparam int unsigned VALUE_W     = 64;
    localparam int unsigned COUNT_W     = 32;
    localparam int unsigned STATUS_W    = 3;
    localparam int unsigned FLAGS_W     = 7;
    localparam int unsigned CFG_INDEX_W = 2;

    localparam int unsigned HEADER_BYTES = 4;
    localparam int unsigned ENTRY_BYTES  = 12;
    localparam int unsigned ENTRY_POS_W  = 4;
    // A 32-bit byte count holds at most (2**32 - 4) / 12 whole entries.
    localparam int unsigned ENTRIES_W    = 29;

    localparam logic [CFG_INDEX_W-1:0] REG_CLASS_MASK_KEY = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SKILL_LOW_KEY  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SKILL_HIGH_KEY = 2'd2;

    localparam logic [KEY_W-1:0] CLASS_MASK_KEY_RESET = 32'd1;
    localparam logic [KEY_W-1:0] SKILL_LOW_KEY_RESET  = 32'd2;
    localparam logic [KEY_W-1:0] SKILL_HIGH_KEY_RESET = 32'd3;

    localparam logic [STATUS_W-1:0] STATUS_VALID     = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_SHORT     = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_TRUNCATED = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_TRAILING  = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 3'd4;

    localparam int unsigned FLAG_HAS_CLASS     = 0;
    localparam int unsigned FLAG_DUP_CLASS     = 1;
    localparam int unsigned FLAG_INVALID_CLASS = 2;
    localparam int unsigned FLAG_HAS_LOW       = 3;
    localparam int unsigned FLAG_DUP_LOW       = 4;
    localparam int unsigned FLAG_HAS_HIGH      = 5;
    localparam int unsigned FLAG_DUP_HIGH      = 6;

    typedef logic [ksrp_pkg::STATUS_W-1:0] status_t;

endpackage

// ----- rtl/core/keyed_stat_record_parser.sv -----
// Channel   Direction  Handshake           Word
// s_        in         s_valid / s_ready   s_data_byte, s_has_byte, s_last_byte
// m_        out        m_valid / m_ready   m_status, m_entry_count, m_capture_flags,
//                                          m_class_mask, m_rejected_class_value,
//                                          m_skill_mask_low, m_skill_mask_high
// cfg_      in         cfg_we              cfg_index, cfg_wdata
//
// One input word is taken per cycle while s_ready is high; each word updates the parse
// state in the cycle it is accepted.
// A word with s_last_byte set loads the result register, so its result appears in the
// cycle after acceptance.
// The result register is the only buffer: s_ready is low only while a result waits
// and m_ready is low.
// Reset clears the parse state and the result valid flag and loads the default keys.
module keyed_stat_record_parser (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [7:0]                         s_data_byte,
    input  logic                               s_has_byte,
    input  logic                               s_last_byte,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [ksrp_pkg::STATUS_W-1:0]      m_status,
    output logic [ksrp_pkg::COUNT_W-1:0]       m_entry_count,
    output logic [ksrp_pkg::FLAGS_W-1:0]       m_capture_flags,
    output logic [ksrp_pkg::KEY_W-1:0]         m_class_mask,
    output logic [ksrp_pkg::VALUE_W-1:0]       m_rejected_class_value,
    output logic [ksrp_pkg::VALUE_W-1:0]       m_skill_mask_low,
    output logic [ksrp_pkg::VALUE_W-1:0]       m_skill_mask_high,
    input  logic                               cfg_we,
    input  logic [ksrp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ksrp_pkg::KEY_W-1:0]         cfg_wdata
);

    logic [ksrp_pkg::KEY_W-1:0]       class_key_reg;
    logic [ksrp_pkg::KEY_W-1:0]       low_key_reg;
    logic [ksrp_pkg::KEY_W-1:0]       high_key_reg;

    logic [ksrp_pkg::COUNT_W-1:0]     byte_total_reg,  byte_total_next;
    logic                             overflow_reg,    overflow_next;
    logic [ksrp_pkg::COUNT_W-1:0]     header_reg,      header_next;
    logic [ksrp_pkg::ENTRY_POS_W-1:0] entry_pos_reg,   entry_pos_next;
    logic [ksrp_pkg::ENTRIES_W-1:0]   entries_reg,     entries_next;
    logic [ksrp_pkg::KEY_W-1:0]       key_reg,         key_next;
    logic [ksrp_pkg::VALUE_W-1:0]     value_reg,       value_next;
    logic [ksrp_pkg::FLAGS_W-1:0]     flags_reg,       flags_next;
    logic [ksrp_pkg::KEY_W-1:0]       class_mask_reg,  class_mask_next;
    logic [ksrp_pkg::VALUE_W-1:0]     rejected_reg,    rejected_next;
    logic [ksrp_pkg::VALUE_W-1:0]     low_mask_reg,    low_mask_next;
    logic [ksrp_pkg::VALUE_W-1:0]     high_mask_reg,   high_mask_next;

    logic                             m_valid_reg;
    ksrp_pkg::status_t                out_status_reg,  out_status_next;
    logic [ksrp_pkg::COUNT_W-1:0]     out_count_reg,   out_count_next;
    logic [ksrp_pkg::FLAGS_W-1:0]     out_flags_reg;
    logic [ksrp_pkg::KEY_W-1:0]       out_class_reg;
    logic [ksrp_pkg::VALUE_W-1:0]     out_rejected_reg;
    logic [ksrp_pkg::VALUE_W-1:0]     out_low_reg;
    logic [ksrp_pkg::VALUE_W-1:0]     out_high_reg;

    logic                             accept;
    logic                             take_byte;
    logic                             header_done;
    logic [ksrp_pkg::VALUE_W-1:0]     full_value;
    logic [2:0]                       value_idx;

    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign take_byte = accept && s_has_byte;
    assign value_idx = 3'(entry_pos_reg - 4'd4);

    always_comb begin
        full_value = value_reg;
        full_value[ksrp_pkg::VALUE_W-1 -: 8] = s_data_byte;
    end

    always_comb begin
        byte_total_next = byte_total_reg;
        overflow_next   = overflow_reg;
        header_next     = header_reg;
        entry_pos_next  = entry_pos_reg;
        entries_next    = entries_reg;
        key_next        = key_reg;
        value_next      = value_reg;
        flags_next      = flags_reg;
        class_mask_next = class_mask_reg;
        rejected_next   = rejected_reg;
        low_mask_next   = low_mask_reg;
        high_mask_next  = high_mask_reg;
        if (take_byte) begin
            if (&byte_total_reg) begin
                overflow_next = 1'b1;
            end else begin
                byte_total_next = byte_total_reg + 32'd1;
                if (byte_total_reg < 32'(ksrp_pkg::HEADER_BYTES)) begin
                    header_next[8*byte_total_reg[1:0] +: 8] = s_data_byte;
                end else if (entry_pos_reg < 4'd4) begin
                    key_next[8*entry_pos_reg[1:0] +: 8] = s_data_byte;
                    entry_pos_next = entry_pos_reg + 4'd1;
                end else if (entry_pos_reg != 4'(ksrp_pkg::ENTRY_BYTES - 1)) begin
                    value_next[8*value_idx +: 8] = s_data_byte;
                    entry_pos_next = entry_pos_reg + 4'd1;
                end else begin
                    if (key_reg == class_key_reg) begin
                        if (|full_value[ksrp_pkg::VALUE_W-1:ksrp_pkg::KEY_W]) begin
                            flags_next[ksrp_pkg::FLAG_INVALID_CLASS] = 1'b1;
                            rejected_next = full_value;
                        end else begin
                            if (flags_reg[ksrp_pkg::FLAG_HAS_CLASS]) begin
                                flags_next[ksrp_pkg::FLAG_DUP_CLASS] = 1'b1;
                            end
                            flags_next[ksrp_pkg::FLAG_HAS_CLASS] = 1'b1;
                            class_mask_next = full_value[ksrp_pkg::KEY_W-1:0];
                        end
                    end else if (key_reg == low_key_reg) begin
                        if (flags_reg[ksrp_pkg::FLAG_HAS_LOW]) begin
                            flags_next[ksrp_pkg::FLAG_DUP_LOW] = 1'b1;
                        end
                        flags_next[ksrp_pkg::FLAG_HAS_LOW] = 1'b1;
                        low_mask_next = full_value;
                    end else if (key_reg == high_key_reg) begin
                        if (flags_reg[ksrp_pkg::FLAG_HAS_HIGH]) begin
                            flags_next[ksrp_pkg::FLAG_DUP_HIGH] = 1'b1;
                        end
                        flags_next[ksrp_pkg::FLAG_HAS_HIGH] = 1'b1;
                        high_mask_next = full_value;
                    end
                    key_next       = '0;
                    value_next     = '0;
                    entry_pos_next = '0;
                    entries_next   = entries_reg + 29'd1;
                end
            end
        end
    end

    // The byte count past the header splits into whole entries and a partial entry, so both
    // length checks reduce to compares against the entry counter and the partial-entry position.
    always_comb begin
        header_done    = |byte_total_next[ksrp_pkg::COUNT_W-1:2];
        out_count_next = header_done ? header_next : '0;
        if (overflow_next) begin
            out_status_next = ksrp_pkg::STATUS_OVERFLOW;
        end else if (!header_done) begin
            out_status_next = ksrp_pkg::STATUS_SHORT;
        end else if (out_count_next > 32'(entries_next)) begin
            out_status_next = ksrp_pkg::STATUS_TRUNCATED;
        end else if (out_count_next != 32'(entries_next) || entry_pos_next != '0) begin
            out_status_next = ksrp_pkg::STATUS_TRAILING;
        end else begin
            out_status_next = ksrp_pkg::STATUS_VALID;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            class_key_reg <= ksrp_pkg::CLASS_MASK_KEY_RESET;
            low_key_reg   <= ksrp_pkg::SKILL_LOW_KEY_RESET;
            high_key_reg  <= ksrp_pkg::SKILL_HIGH_KEY_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                ksrp_pkg::REG_CLASS_MASK_KEY: class_key_reg <= cfg_wdata;
                ksrp_pkg::REG_SKILL_LOW_KEY:  low_key_reg   <= cfg_wdata;
                ksrp_pkg::REG_SKILL_HIGH_KEY: high_key_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && s_last_byte)) begin
            byte_total_reg <= '0;
            overflow_reg   <= 1'b0;
            header_reg     <= '0;
            entry_pos_reg  <= '0;
            entries_reg    <= '0;
            key_reg        <= '0;
            value_reg      <= '0;
            flags_reg      <= '0;
            class_mask_reg <= '0;
            rejected_reg   <= '0;
            low_mask_reg   <= '0;
            high_mask_reg  <= '0;
        end else begin
            byte_total_reg <= byte_total_next;
            overflow_reg   <= overflow_next;
            header_reg     <= header_next;
            entry_pos_reg  <= entry_pos_next;
            entries_reg    <= entries_next;
            key_reg        <= key_next;
            value_reg      <= value_next;
            flags_reg      <= flags_next;
            class_mask_reg <= class_mask_next;
            rejected_reg   <= rejected_next;
            low_mask_reg   <= low_mask_next;
            high_mask_reg  <= high_mask_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept && s_last_byte) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_last_byte) begin
            out_status_reg <= out_status_next;
            out_count_reg  <= out_count_next;
            if (out_status_next == ksrp_pkg::STATUS_VALID) begin
                out_flags_reg    <= flags_next;
                out_class_reg    <= class_mask_next;
                out_rejected_reg <= rejected_next;
                out_low_reg      <= low_mask_next;
                out_high_reg     <= high_mask_next;
            end else begin
                out_flags_reg    <= '0;
                out_class_reg    <= '0;
                out_rejected_reg <= '0;
                out_low_reg      <= '0;
                out_high_reg     <= '0;
            end
        end
    end

    assign m_valid                = m_valid_reg;
    assign m_status               = out_status_reg;
    assign m_entry_count          = out_count_reg;
    assign m_capture_flags        = out_flags_reg;
    assign m_class_mask           = out_class_reg;
    assign m_rejected_class_value = out_rejected_reg;
    assign m_skill_mask_low       = out_low_reg;
    assign m_skill_mask_high      = out_high_reg;

`ifndef ASSERT_OFF
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        entry_pos_reg < 4'(ksrp_pkg::ENTRY_BYTES))
        else $error("entry position out of range");

    a_overflow_saturated: assert property (@(posedge aclk) disable iff (!aresetn)
        overflow_reg |-> (&byte_total_reg))
        else $error("overflow flagged without a saturated byte count");

    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_last_byte) |=> m_valid_reg)
        else $error("end of payload did not load a result");

    a_bad_status_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_status_reg != ksrp_pkg::STATUS_VALID) |->
        (out_flags_reg == '0 && out_class_reg == '0 && out_rejected_reg == '0 &&
         out_low_reg == '0 && out_high_reg == '0))
        else $error("failed payload carries captured fields");

    a_short_no_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_status_reg == ksrp_pkg::STATUS_SHORT) |->
        out_count_reg == '0)
        else $error("short payload reports an entry count");
`endif

endmodule
